[rtl/core/tsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsa_pkg: shared definitions for the texture slot allocator
// Sizes, address helpers, status and opcode codes, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam int SLOTS_PER_POOL = 256;
	localparam int POOL_COUNT     = 3;
	localparam int TOTAL_SLOTS    = SLOTS_PER_POOL * POOL_COUNT;

	localparam int ID_W     = 32;
	localparam int OUT_SLOT_W = 8;
	localparam int HEAD_W   = $clog2(SLOTS_PER_POOL + 1);
	localparam int POOL_W   = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
	localparam int ADDR_W   = $clog2(TOTAL_SLOTS);
	localparam int OWNER_W  = ID_W + 1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic load;
		logic scan;
		logic next_pool;
		logic alloc;
		logic pop;
		logic release_wr;
		logic res_invalid;
		logic res_hit;
		logic res_full;
		logic res_unknown;
		logic res_new;
	} ctrl_cmd_t;

	typedef struct packed {
		logic id_zero;
		logic is_release;
		logic hit;
		logic scan_end;
		logic last_pool;
		logic head_empty;
		logic head_fresh;
	} dp_stat_t;

	// Flat memory address of a slot within a pool.
	function automatic logic [ADDR_W-1:0] slot_addr(
		input logic [POOL_W-1:0] pool,
		input logic [HEAD_W-1:0] slot
	);
		slot_addr = ADDR_W'(pool) * ADDR_W'(SLOTS_PER_POOL) + ADDR_W'(slot);
	endfunction

endpackage
`default_nettype wire

[rtl/core/texture_slot_allocator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// texture_slot_allocator_unit: texture slot allocator
// Three slot pools, one per texture class, each with a linked free list and
// an owner store; acquires look up or allocate a slot, releases free one.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge with start high and busy low, and busy
// stays high until its result is out. Each item gives exactly one result beat,
// shown for a single cycle with done high; the receiver cannot stall it, so it
// must take the beat in that cycle. The length of an item is set by a linear
// scan of the owner memory at one slot per cycle through its single read port.
// Only slots that were ever handed out in a pool are scanned; an acquire that
// pops a recycled slot from the free list passes through an extra pop state.
// A release scans the pools in order until it finds the id. An invalid (zero)
// id finishes without scanning. No clearing pass is needed after reset: a
// per-pool fill mark tells slots that were never handed out from slots whose
// memory entries are valid.
// ----------------------------------------------------------------------------
module texture_slot_allocator_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               opcode,
	input  wire logic [tsa_pkg::ID_W-1:0]           object_id,
	input  wire logic [1:0]                         texture_class,
	output logic                                    done,
	output logic [tsa_pkg::OUT_SLOT_W-1:0]          slot_index,
	output logic                                    was_present,
	output logic [1:0]                              status
);

	import tsa_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The controller walks the scan and decides the outcome; the datapath
	// holds all storage and forms the result beat.
	tsa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	tsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.object_id    (object_id),
		.texture_class(texture_class),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.slot_index   (slot_index),
		.was_present  (was_present),
		.status       (status)
	);

	// The result beat appears only once the block is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An accepted item keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

endmodule
`default_nettype wire

[rtl/core/tsa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsa_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/tsa_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsa_dp: allocator datapath
// Owner and link memories, per-pool free-list heads and fill marks, the slot
// scan, and the result register.
// ----------------------------------------------------------------------------
module tsa_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             opcode,
	input  wire logic [tsa_pkg::ID_W-1:0]         object_id,
	input  wire logic [1:0]                       texture_class,
	input  wire tsa_pkg::ctrl_cmd_t               cmd,
	output tsa_pkg::dp_stat_t                     stat,
	output logic                                  done,
	output logic [tsa_pkg::OUT_SLOT_W-1:0]        slot_index,
	output logic                                  was_present,
	output logic [1:0]                            status
);

	import tsa_pkg::*;

	logic               op_q;
	logic [ID_W-1:0]    id_q;
	logic [POOL_W-1:0]  pool_q;
	logic [HEAD_W-1:0]  scan_q;
	logic               chk_s1;
	logic [HEAD_W-1:0]  slot_s1;
	logic [HEAD_W-1:0]  head_q [POOL_COUNT];
	logic [HEAD_W-1:0]  hw_q   [POOL_COUNT];

	logic [HEAD_W-1:0]  head_cur;
	logic [HEAD_W-1:0]  hw_cur;
	logic [POOL_W-1:0]  pool_sel;
	logic               issue;

	logic               owner_we;
	logic [ADDR_W-1:0]  owner_waddr;
	logic [OWNER_W-1:0] owner_rdata;
	logic [HEAD_W-1:0]  link_rdata;

	logic               done_q;
	logic [HEAD_W-1:0]  res_slot_q;
	logic               res_present_q;
	logic [1:0]         res_status_q;

	assign head_cur = head_q[pool_q];
	assign hw_cur   = hw_q[pool_q];
	assign issue    = scan_q < hw_cur;
	assign pool_sel = (int'(texture_class) < POOL_COUNT) ? POOL_W'(texture_class) : '0;

	// Slots at or above the fill mark were never handed out, so their
	// in-use bit is known to be clear and their link is the next slot.
	always_comb begin
		stat.id_zero    = id_q == '0;
		stat.is_release = op_q == OP_RELEASE;
		stat.hit        = chk_s1 && owner_rdata[OWNER_W-1] && (owner_rdata[ID_W-1:0] == id_q);
		stat.scan_end   = !chk_s1 && !issue;
		stat.last_pool  = pool_q == POOL_W'(POOL_COUNT - 1);
		stat.head_empty = head_cur == HEAD_W'(SLOTS_PER_POOL);
		stat.head_fresh = head_cur == hw_cur;
	end

	assign owner_we    = cmd.alloc || cmd.release_wr;
	assign owner_waddr = cmd.release_wr ? slot_addr(pool_q, slot_s1) : slot_addr(pool_q, head_cur);

	tsa_ram #(
		.WIDTH(OWNER_W),
		.DEPTH(TOTAL_SLOTS)
	) u_owner_ram (
		.clk  (clk),
		.we   (owner_we),
		.waddr(owner_waddr),
		.wdata({cmd.alloc, id_q}),
		.raddr(slot_addr(pool_q, scan_q)),
		.rdata(owner_rdata)
	);

	tsa_ram #(
		.WIDTH(HEAD_W),
		.DEPTH(TOTAL_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (cmd.release_wr),
		.waddr(slot_addr(pool_q, slot_s1)),
		.wdata(head_cur),
		.raddr(slot_addr(pool_q, head_cur)),
		.rdata(link_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			id_q <= object_id;
		end
		if (cmd.scan) begin
			slot_s1 <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= '0;
			scan_q <= '0;
			chk_s1 <= 1'b0;
			for (int i = 0; i < POOL_COUNT; i++) begin
				head_q[i] <= '0;
				hw_q[i]   <= '0;
			end
		end else begin
			if (cmd.load) begin
				pool_q <= (opcode == OP_RELEASE) ? '0 : pool_sel;
				scan_q <= '0;
				chk_s1 <= 1'b0;
			end else if (cmd.next_pool) begin
				pool_q <= pool_q + POOL_W'(1);
				scan_q <= '0;
				chk_s1 <= 1'b0;
			end else if (cmd.scan) begin
				chk_s1 <= issue;
				if (issue) begin
					scan_q <= scan_q + HEAD_W'(1);
				end
			end
			if (cmd.alloc && stat.head_fresh) begin
				head_q[pool_q] <= head_cur + HEAD_W'(1);
				hw_q[pool_q]   <= hw_cur + HEAD_W'(1);
			end else if (cmd.pop) begin
				head_q[pool_q] <= link_rdata;
			end else if (cmd.release_wr) begin
				head_q[pool_q] <= slot_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_invalid || cmd.res_hit || cmd.release_wr || cmd.res_full
				|| cmd.res_unknown || cmd.res_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_hit || cmd.release_wr) begin
			res_slot_q    <= slot_s1;
			res_present_q <= 1'b1;
			res_status_q  <= ST_OK;
		end else if (cmd.res_new) begin
			res_slot_q    <= head_cur;
			res_present_q <= 1'b0;
			res_status_q  <= ST_OK;
		end else if (cmd.res_full) begin
			res_slot_q    <= '0;
			res_present_q <= 1'b0;
			res_status_q  <= ST_FULL;
		end else if (cmd.res_unknown) begin
			res_slot_q    <= '0;
			res_present_q <= 1'b0;
			res_status_q  <= ST_UNKNOWN;
		end else if (cmd.res_invalid) begin
			res_slot_q    <= '0;
			res_present_q <= 1'b0;
			res_status_q  <= ST_INVALID;
		end
	end

	assign done        = done_q;
	assign slot_index  = OUT_SLOT_W'(res_slot_q);
	assign was_present = res_present_q;
	assign status      = res_status_q;

	// The free-list head never runs past the fill mark of its pool.
	a_head_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		head_cur <= hw_cur)
		else $error("free-list head beyond fill mark");

	// A hit only comes from a read that was actually issued below the mark.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit |-> slot_s1 < hw_cur)
		else $error("hit on a slot never handed out");

endmodule
`default_nettype wire

[rtl/core/tsa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsa_ctrl: allocator controller
// Sequences the scan, the allocate and release updates, and the result.
// ----------------------------------------------------------------------------
module tsa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire tsa_pkg::dp_stat_t  stat,
	output tsa_pkg::ctrl_cmd_t      cmd,
	output logic                    busy
);

	import tsa_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_ALLOC = 2'd2;
	localparam logic [1:0] S_POP   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.id_zero) begin
					cmd.res_invalid = 1'b1;
					state_d         = S_IDLE;
				end else if (stat.hit) begin
					if (stat.is_release) begin
						cmd.release_wr = 1'b1;
					end else begin
						cmd.res_hit = 1'b1;
					end
					state_d = S_IDLE;
				end else if (stat.scan_end) begin
					if (!stat.is_release) begin
						if (stat.head_empty) begin
							cmd.res_full = 1'b1;
							state_d      = S_IDLE;
						end else begin
							state_d = S_ALLOC;
						end
					end else if (stat.last_pool) begin
						cmd.res_unknown = 1'b1;
						state_d         = S_IDLE;
					end else begin
						cmd.next_pool = 1'b1;
					end
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				if (stat.head_fresh) begin
					cmd.res_new = 1'b1;
					state_d     = S_IDLE;
				end else begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				cmd.pop     = 1'b1;
				cmd.res_new = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.res_invalid, cmd.res_hit, cmd.release_wr, cmd.res_full,
			cmd.res_unknown, cmd.res_new}))
		else $error("more than one result in a cycle");

	a_pop_after_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> $past(cmd.alloc))
		else $error("free-list pop without a preceding allocate");

endmodule
`default_nettype wire
